### design/ffha_pkg.sv
// Package for the first-fit heap allocator.
// Holds the block table entry type, operation and status codes, and reset values.
// Used by first_fit_heap_allocator_top; depends on nothing.
package ffha_pkg;

   localparam int OFF_W = 24;

   typedef struct packed {
      logic [OFF_W-1:0] start;
      logic [OFF_W-1:0] size;
      logic             free;
   } blk_type;

   localparam logic [1:0] FUNC_ALLOC  = 2'd0;
   localparam logic [1:0] FUNC_FREE   = 2'd1;
   localparam logic [1:0] FUNC_RESIZE = 2'd2;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NO_SPACE = 2'd1;
   localparam logic [1:0] ST_BAD_ADDR = 2'd2;

   localparam logic       CSR_HEAP_BASE  = 1'b0;
   localparam logic       CSR_HEAP_BYTES = 1'b1;

   localparam logic [31:0]      HEAP_BASE_RST  = 32'h9000_0000;
   localparam logic [OFF_W-1:0] HEAP_BYTES_RST = 24'h10_0000;

endpackage

### design/first_fit_heap_allocator_top.sv
// Top level of the first-fit heap allocator: block table memory and its sequencer.
// Depends on ffha_pkg for the entry type, codes and reset values.
//
// A request is taken when start is high and busy is low; busy stays high until the
// single response is shown on the rsp_ ports for one cycle with rsp_valid, which
// the receiver must take then. Table accesses go through the block table, which has one
// registered read port and one write port, so the time for a request depends on the
// table contents: an allocate does a first-fit scan plus the entry moves of a split, a
// free an address scan plus the entry moves of two merges, and a resize that has to move
// its block an address scan, an allocate, a second address scan and a free.

module first_fit_heap_allocator_top #(
   parameter int MAX_BLOCKS   = 64,
   parameter int HEADER_BYTES = 24
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_func,
   input  logic [23:0] req_size,
   input  logic [31:0] req_addr,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_data_addr,
   output logic        rsp_copy_needed,
   output logic [31:0] rsp_copy_from,
   output logic [23:0] rsp_copy_bytes,
   input  logic        csr_we,
   input  logic        csr_idx,
   input  logic [31:0] csr_wdata
);

   localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int CW = $clog2(MAX_BLOCKS + 1);
   localparam logic [CW-1:0] MAXC = CW'(MAX_BLOCKS);
   localparam logic [25:0] HDR = 26'(HEADER_BYTES);
   localparam logic [25:0] SPLIT_MIN = 26'(HEADER_BYTES + 8);

   typedef enum logic [4:0] {
      S_IDLE, S_DISP, S_FIND_RD, S_FIND_CHK, S_RSZ, S_RSZ_NXQ, S_A_RD, S_A_CHK,
      S_APPEND, S_SPLIT, S_SHU_RD, S_SHU_WR, S_SPL_NEW, S_WB, S_SHD_RD, S_SHD_WR,
      S_REL, S_REL_PRV, S_REL_NXT, S_REL_NXQ, S_REL_WB, S_FIN
   } state_type;

   state_type state_ff, ret_ff;

   ffha_pkg::blk_type mem [MAX_BLOCKS];
   ffha_pkg::blk_type q_ff, cur_ff, wr_data, new_blk;
   logic              wr_en;
   logic [IW-1:0]     wr_idx, rd_idx;

   logic [31:0]   base_ff, addr_ff, off_ff;
   logic [23:0]   hbytes_ff, brk_ff, old_ff;
   logic [24:0]   s_ff;
   logic [1:0]    func_ff;
   logic [CW-1:0] count_ff, j_ff;
   logic [IW-1:0] idx_ff;
   logic          mv_ff, alc_ff;

   logic          valid_ff, copy_ff;
   logic [1:0]    status_ff;
   logic [31:0]   data_ff, from_ff;
   logic [23:0]   bytes_ff;

   logic [CW-1:0] idx_p1;
   logic [25:0]   rest, app_end, fuse_q;
   logic [31:0]   off_calc;

   assign idx_p1   = CW'(idx_ff) + CW'(1);
   assign rest     = {2'b0, cur_ff.size} - {1'b0, s_ff};
   assign app_end  = {2'b0, brk_ff} + HDR + {1'b0, s_ff};
   assign fuse_q   = {2'b0, cur_ff.size} + HDR + {2'b0, q_ff.size};
   assign off_calc = req_addr - base_ff;

   always_comb begin
      new_blk.start = 24'({2'b0, cur_ff.start} + HDR + {1'b0, s_ff});
      new_blk.size  = 24'(rest - HDR);
      new_blk.free  = 1'b1;
   end

   always_comb begin
      rd_idx  = j_ff[IW-1:0];
      wr_en   = 1'b0;
      wr_idx  = idx_ff;
      wr_data = cur_ff;
      case (state_ff)
         S_RSZ, S_REL_NXT: rd_idx = idx_p1[IW-1:0];
         S_REL:            rd_idx = idx_ff - IW'(1);
         S_SHU_RD:         rd_idx = j_ff[IW-1:0] - IW'(1);
         S_SHD_RD:         rd_idx = j_ff[IW-1:0] + IW'(1);
         default:          rd_idx = j_ff[IW-1:0];
      endcase
      case (state_ff)
         S_SHU_WR, S_SHD_WR: begin
            wr_en   = 1'b1;
            wr_idx  = j_ff[IW-1:0];
            wr_data = q_ff;
         end
         S_SPL_NEW: begin
            wr_en   = 1'b1;
            wr_idx  = idx_p1[IW-1:0];
            wr_data = new_blk;
         end
         S_WB, S_REL_WB: begin
            wr_en = 1'b1;
         end
         S_APPEND: begin
            wr_en   = (count_ff < MAXC) && (app_end <= {2'b0, hbytes_ff});
            wr_idx  = count_ff[IW-1:0];
            wr_data = '{start: brk_ff, size: s_ff[23:0], free: 1'b0};
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
      q_ff <= mem[rd_idx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff   <= ffha_pkg::HEAP_BASE_RST;
         hbytes_ff <= ffha_pkg::HEAP_BYTES_RST;
      end else if (csr_we) begin
         case (csr_idx)
            ffha_pkg::CSR_HEAP_BASE:  base_ff   <= csr_wdata;
            ffha_pkg::CSR_HEAP_BYTES: hbytes_ff <= csr_wdata[23:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ret_ff   <= S_IDLE;
         count_ff <= '0;
         brk_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               valid_ff <= 1'b0;
               if (start) begin
                  func_ff  <= req_func;
                  addr_ff  <= req_addr;
                  off_ff   <= off_calc;
                  s_ff     <= ({1'b0, req_size} + 25'd7) & ~25'd7;
                  state_ff <= S_DISP;
               end
            end
            S_DISP: begin
               data_ff   <= '0;
               copy_ff   <= 1'b0;
               from_ff   <= '0;
               bytes_ff  <= '0;
               mv_ff     <= 1'b0;
               j_ff      <= '0;
               if (func_ff == ffha_pkg::FUNC_ALLOC ||
                   (func_ff == ffha_pkg::FUNC_RESIZE && addr_ff == '0)) begin
                  status_ff <= ffha_pkg::ST_OK;
                  alc_ff    <= 1'b1;
                  state_ff  <= S_A_RD;
               end else if (func_ff == ffha_pkg::FUNC_FREE ||
                            func_ff == ffha_pkg::FUNC_RESIZE) begin
                  alc_ff <= 1'b0;
                  if (off_ff < 32'(HEADER_BYTES) || off_ff >= {8'b0, brk_ff}) begin
                     status_ff <= ffha_pkg::ST_BAD_ADDR;
                     state_ff  <= S_FIN;
                  end else begin
                     status_ff <= ffha_pkg::ST_OK;
                     state_ff  <= S_FIND_RD;
                  end
               end else begin
                  status_ff <= ffha_pkg::ST_OK;
                  alc_ff    <= 1'b0;
                  state_ff  <= S_FIN;
               end
            end
            S_FIND_RD: begin
               if (j_ff == count_ff) begin
                  if (!mv_ff) begin
                     status_ff <= ffha_pkg::ST_BAD_ADDR;
                  end
                  state_ff <= S_FIN;
               end else begin
                  state_ff <= S_FIND_CHK;
               end
            end
            S_FIND_CHK: begin
               if ({8'b0, q_ff.start} + 32'(HEADER_BYTES) == off_ff) begin
                  idx_ff   <= j_ff[IW-1:0];
                  cur_ff   <= q_ff;
                  state_ff <= (func_ff == ffha_pkg::FUNC_RESIZE && !mv_ff) ? S_RSZ : S_REL;
               end else begin
                  j_ff     <= j_ff + CW'(1);
                  state_ff <= S_FIND_RD;
               end
            end
            S_RSZ: begin
               if ({1'b0, cur_ff.size} >= s_ff) begin
                  data_ff  <= addr_ff;
                  state_ff <= S_SPLIT;
               end else if (idx_p1 < count_ff) begin
                  data_ff  <= addr_ff;
                  state_ff <= S_RSZ_NXQ;
               end else begin
                  old_ff   <= cur_ff.size;
                  mv_ff    <= 1'b1;
                  alc_ff   <= 1'b1;
                  data_ff  <= '0;
                  j_ff     <= '0;
                  state_ff <= S_A_RD;
               end
            end
            S_RSZ_NXQ: begin
               if (q_ff.free && fuse_q >= {1'b0, s_ff}) begin
                  cur_ff.size <= fuse_q[23:0];
                  j_ff        <= idx_p1;
                  ret_ff      <= S_SPLIT;
                  state_ff    <= S_SHD_RD;
               end else begin
                  old_ff   <= cur_ff.size;
                  mv_ff    <= 1'b1;
                  alc_ff   <= 1'b1;
                  data_ff  <= '0;
                  j_ff     <= '0;
                  state_ff <= S_A_RD;
               end
            end
            S_A_RD: begin
               state_ff <= (j_ff == count_ff) ? S_APPEND : S_A_CHK;
            end
            S_A_CHK: begin
               if (q_ff.free && {1'b0, q_ff.size} >= s_ff) begin
                  idx_ff   <= j_ff[IW-1:0];
                  cur_ff   <= '{start: q_ff.start, size: q_ff.size, free: 1'b0};
                  data_ff  <= base_ff + {8'b0, q_ff.start} + 32'(HEADER_BYTES);
                  state_ff <= S_SPLIT;
               end else begin
                  j_ff     <= j_ff + CW'(1);
                  state_ff <= S_A_RD;
               end
            end
            S_APPEND: begin
               if (count_ff >= MAXC || app_end > {2'b0, hbytes_ff}) begin
                  status_ff <= ffha_pkg::ST_NO_SPACE;
                  state_ff  <= S_FIN;
               end else begin
                  data_ff  <= base_ff + {8'b0, brk_ff} + 32'(HEADER_BYTES);
                  count_ff <= count_ff + CW'(1);
                  brk_ff   <= app_end[23:0];
                  j_ff     <= '0;
                  state_ff <= mv_ff ? S_FIND_RD : S_FIN;
               end
            end
            S_SPLIT: begin
               if (rest >= SPLIT_MIN && count_ff < MAXC) begin
                  j_ff     <= count_ff;
                  state_ff <= S_SHU_RD;
               end else begin
                  state_ff <= S_WB;
               end
            end
            S_SHU_RD: begin
               state_ff <= (j_ff > idx_p1) ? S_SHU_WR : S_SPL_NEW;
            end
            S_SHU_WR: begin
               j_ff     <= j_ff - CW'(1);
               state_ff <= S_SHU_RD;
            end
            S_SPL_NEW: begin
               cur_ff.size <= s_ff[23:0];
               count_ff    <= count_ff + CW'(1);
               state_ff    <= S_WB;
            end
            S_WB: begin
               j_ff     <= '0;
               state_ff <= (alc_ff && mv_ff) ? S_FIND_RD : S_FIN;
            end
            S_SHD_RD: begin
               if (j_ff + CW'(1) < count_ff) begin
                  state_ff <= S_SHD_WR;
               end else begin
                  count_ff <= count_ff - CW'(1);
                  state_ff <= ret_ff;
               end
            end
            S_SHD_WR: begin
               j_ff     <= j_ff + CW'(1);
               state_ff <= S_SHD_RD;
            end
            S_REL: begin
               cur_ff.free <= 1'b1;
               state_ff    <= (idx_ff != '0) ? S_REL_PRV : S_REL_NXT;
            end
            S_REL_PRV: begin
               if (q_ff.free) begin
                  cur_ff   <= '{start: q_ff.start,
                                size: 24'({2'b0, q_ff.size} + HDR + {2'b0, cur_ff.size}),
                                free: 1'b1};
                  idx_ff   <= idx_ff - IW'(1);
                  j_ff     <= CW'(idx_ff);
                  ret_ff   <= S_REL_NXT;
                  state_ff <= S_SHD_RD;
               end else begin
                  state_ff <= S_REL_NXT;
               end
            end
            S_REL_NXT: begin
               if (idx_p1 < count_ff) begin
                  state_ff <= S_REL_NXQ;
               end else begin
                  brk_ff   <= cur_ff.start;
                  count_ff <= count_ff - CW'(1);
                  state_ff <= S_FIN;
               end
            end
            S_REL_NXQ: begin
               if (q_ff.free) begin
                  cur_ff.size <= fuse_q[23:0];
                  j_ff        <= idx_p1;
                  ret_ff      <= S_REL_WB;
                  state_ff    <= S_SHD_RD;
               end else begin
                  state_ff <= S_REL_WB;
               end
            end
            S_REL_WB: begin
               state_ff <= S_FIN;
            end
            S_FIN: begin
               if (mv_ff && status_ff == ffha_pkg::ST_OK) begin
                  copy_ff  <= 1'b1;
                  from_ff  <= addr_ff;
                  bytes_ff <= old_ff;
               end
               valid_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign busy            = (state_ff != S_IDLE);
   assign rsp_valid       = valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_data_addr   = data_ff;
   assign rsp_copy_needed = copy_ff;
   assign rsp_copy_from   = from_ff;
   assign rsp_copy_bytes  = bytes_ff;

   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("response without a request in progress");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not raise busy");

   a_bad_addr_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ffha_pkg::ST_BAD_ADDR) |->
         (rsp_data_addr == '0 && !rsp_copy_needed))
      else $error("invalid address response carries data");

   a_copy_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_copy_needed) |-> (rsp_status == ffha_pkg::ST_OK))
      else $error("copy request with failing status");

   a_count_max: assert property (@(posedge clock) disable iff (reset)
      busy |-> (count_ff <= MAXC))
      else $error("block count above table depth");

endmodule
